### hw/rtl/md5_round_steps_macros.svh
// Assertion macros for the md5_round_steps checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MD5_ROUND_STEPS_MACROS_SVH
`define MD5_ROUND_STEPS_MACROS_SVH

// Implication in the same cycle.
`define MD5_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle.
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/md5rs_pkg.sv
// Shared types, tables and step functions of the MD5 round-step engine.
// No dependencies.
package md5rs_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned IdxW  = 4;
	localparam int unsigned CntW  = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef enum logic {
		CMD_WORK = 1'b0,
		CMD_MSG  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_C = 2'd2,
		SEL_D = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		RND_F = 2'd0,
		RND_G = 2'd1,
		RND_H = 2'd2,
		RND_I = 2'd3
	} round_t;

	typedef struct packed {
		logic s_ready;
		logic rd_en;
		logic step;
		logic out_load;
	} ctrl_t;

	function automatic logic [IdxW-1:0] msg_index(input logic [CntW-1:0] cnt);
		logic [IdxW-1:0] t;
		logic [IdxW-1:0] mi;
		t = cnt[IdxW-1:0];
		case (round_t'(cnt[5:4]))
			RND_F: mi = t;
			RND_G: mi = {t[1:0], 2'b00} + t + 4'd1;
			RND_H: mi = {t[2:0], 1'b0} + t + 4'd5;
			RND_I: mi = {t[0], 3'b000} - t;
			default: mi = t;
		endcase
		return mi;
	endfunction

	function automatic logic [4:0] shift_amt(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0: s = 5'd7;
			4'd1: s = 5'd12;
			4'd2: s = 5'd17;
			4'd3: s = 5'd22;
			4'd4: s = 5'd5;
			4'd5: s = 5'd9;
			4'd6: s = 5'd14;
			4'd7: s = 5'd20;
			4'd8: s = 5'd4;
			4'd9: s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	function automatic logic [WordW-1:0] sine_k(input logic [CntW-1:0] n);
		logic [WordW-1:0] k;
		case (n)
			6'd0: k = 32'hd76aa478;
			6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;
			6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;
			6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'hd76aa478;
		endcase
		return k;
	endfunction

endpackage

### hw/rtl/md5rs_msg_ram.sv
// Sixteen-word message store, one write and one registered read port.
// Uses md5rs_pkg.
module md5rs_msg_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [md5rs_pkg::IdxW-1:0]  waddr,
	input  logic [md5rs_pkg::WordW-1:0] wdata,
	input  logic                     re,
	input  logic [md5rs_pkg::IdxW-1:0]  raddr,
	output logic [md5rs_pkg::WordW-1:0] rdata
);
	import md5rs_pkg::*;

	logic [WordW-1:0] mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/md5rs_step_unit.sv
// One MD5 step: round function, constant, rotate and add giving the new B.
// Uses md5rs_pkg.
module md5rs_step_unit (
	input  logic [md5rs_pkg::WordW-1:0] a,
	input  logic [md5rs_pkg::WordW-1:0] b,
	input  logic [md5rs_pkg::WordW-1:0] c,
	input  logic [md5rs_pkg::WordW-1:0] d,
	input  logic [md5rs_pkg::WordW-1:0] m,
	input  logic [md5rs_pkg::CntW-1:0]  cnt,
	output logic [md5rs_pkg::WordW-1:0] new_b
);
	import md5rs_pkg::*;

	logic [WordW-1:0]   fv;
	logic [WordW-1:0]   sum;
	logic [4:0]         sh;
	logic [2*WordW-1:0] dbl;

	always_comb begin
		case (round_t'(cnt[5:4]))
			RND_F: fv = (b & c) | (~b & d);
			RND_G: fv = (b & d) | (c & ~d);
			RND_H: fv = b ^ c ^ d;
			RND_I: fv = c ^ (b | ~d);
			default: fv = b ^ c ^ d;
		endcase
	end

	assign sum   = a + fv + m + sine_k(cnt);
	assign sh    = shift_amt({cnt[5:4], cnt[1:0]});
	assign dbl   = {sum, sum} << sh;
	assign new_b = b + dbl[2*WordW-1:WordW];

endmodule

### hw/rtl/md5rs_ctrl.sv
// Sequencer: load, read prime, 64 steps, result hand-off.
// Uses md5rs_pkg.
module md5rs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             start,
	input  logic             last_step,
	input  logic             out_free,
	output md5rs_pkg::ctrl_t ctrl
);
	import md5rs_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && start) state_next = ST_PRIME;
			end
			ST_PRIME: begin
				state_next = ST_RUN;
			end
			ST_RUN: begin
				if (last_step) state_next = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.s_ready = 1'b1;
			end
			ST_PRIME: begin
				ctrl.rd_en = 1'b1;
			end
			ST_RUN: begin
				ctrl.rd_en = 1'b1;
				ctrl.step  = 1'b1;
			end
			ST_HOLD: begin
				ctrl.out_load = out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

### hw/rtl/md5_round_steps.sv
// MD5 round-step engine top: working words, step counter, result register.
// Uses md5rs_pkg, md5rs_msg_ram, md5rs_step_unit, md5rs_ctrl.
//
//  channel | dir | tdata                          | tuser     | tlast
//  s_      | in  | word_index[3:0] data_word[35:4] | command   | last
//  m_      | out | out_a out_b out_c out_d (x32)   | -         | -
//
// A last-marked message transfer starts a run to the result: one read prime, then 64
// steps through the single step unit (one message-store read each), then the load into
// the output register.
// Reset clears working words, counter and control; the message store is not cleared.
// m_tready low holds the result; a following run then waits before hand-off.
module md5_round_steps (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,  // word_index[3:0], data_word[35:4], zero[39:36]
	input  logic          s_tuser,  // command[0]
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata   // out_a[31:0], out_b[63:32], out_c[95:64], out_d[127:96]
);
	import md5rs_pkg::*;

	ctrl_t            ctrl;
	logic [IdxW-1:0]  in_idx;
	logic [WordW-1:0] in_word;
	logic             accept;
	logic             is_msg;
	logic             start;
	logic             out_free;
	logic [CntW-1:0]  cnt_q;
	logic [CntW-1:0]  rd_cnt;
	logic [IdxW-1:0]  raddr;
	logic [WordW-1:0] msg_word;
	logic [WordW-1:0] new_b;
	logic [WordW-1:0] a_q, b_q, c_q, d_q;
	logic             m_tvalid_q;
	logic [127:0]     m_tdata_q;

	assign in_idx   = s_tdata[3:0];
	assign in_word  = s_tdata[35:4];
	assign s_tready = ctrl.s_ready;
	assign accept   = s_tvalid && ctrl.s_ready;
	assign is_msg   = (cmd_t'(s_tuser) == CMD_MSG);
	assign start    = is_msg && s_tlast;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_cnt   = ctrl.step ? cnt_q + 6'd1 : cnt_q;
	assign raddr    = msg_index(rd_cnt);

	md5rs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.start     (start),
		.last_step (cnt_q == 6'd63),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	md5rs_msg_ram u_ram (
		.clk   (clk),
		.we    (accept && is_msg),
		.waddr (in_idx),
		.wdata (in_word),
		.re    (ctrl.rd_en),
		.raddr (raddr),
		.rdata (msg_word)
	);

	md5rs_step_unit u_step (
		.a     (a_q),
		.b     (b_q),
		.c     (c_q),
		.d     (d_q),
		.m     (msg_word),
		.cnt   (cnt_q),
		.new_b (new_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			c_q   <= '0;
			d_q   <= '0;
			cnt_q <= '0;
		end else if (ctrl.step) begin
			a_q   <= d_q;
			b_q   <= new_b;
			c_q   <= b_q;
			d_q   <= c_q;
			cnt_q <= cnt_q + 6'd1;
		end else if (accept && !is_msg && (in_idx[3:2] == 2'b00)) begin
			case (sel_t'(in_idx[1:0]))
				SEL_A: a_q <= in_word;
				SEL_B: b_q <= in_word;
				SEL_C: c_q <= in_word;
				SEL_D: d_q <= in_word;
				default: a_q <= a_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata_q <= {d_q, c_q, b_q, a_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hw/rtl/md5rs_checker.sv
// Port-level checks for md5_round_steps, bound to the top level.
// Uses md5_round_steps_macros.svh.
`include "md5_round_steps_macros.svh"

module md5rs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	`MD5_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`MD5_ASSERT_NEXT(a_start_busy, s_tvalid && s_tready && s_tuser && s_tlast, !s_tready, "input still ready after a run was started")
	`MD5_ASSERT_NEXT(a_load_ready, s_tvalid && s_tready && !(s_tuser && s_tlast), s_tready, "plain load transfer made the block busy")
	`MD5_ASSERT_SAME(a_result_src, $rose(m_tvalid), !$past(s_tready), "result appeared without a run")

endmodule

bind md5_round_steps md5rs_checker u_checker (.*);
